// File: hw/rtl/scmd_pkg.sv
// ----------------------------------------------------------------------------
// scmd_pkg
// Shared types, character codes and helper functions of the serial command
// mode decoder.
// ----------------------------------------------------------------------------
package scmd_pkg;

  localparam logic [7:0]  CHAR_CR        = 8'h0D;
  localparam logic [7:0]  CHAR_LF        = 8'h0A;
  localparam logic [7:0]  CHAR_UPPER_A   = 8'h41;
  localparam logic [7:0]  CHAR_UPPER_Z   = 8'h5A;
  localparam logic [7:0]  CASE_OFFSET    = 8'h20;
  localparam logic [7:0]  CHAR_M         = 8'h6D;
  localparam logic [7:0]  CHAR_N         = 8'h6E;
  localparam logic [7:0]  CHAR_Z         = 8'h7A;
  localparam logic [7:0]  CHAR_X         = 8'h78;
  localparam logic [7:0]  CHAR_I         = 8'h69;
  localparam logic [7:0]  CHAR_W         = 8'h77;
  localparam logic [7:0]  CHAR_A         = 8'h61;
  localparam logic [7:0]  CHAR_S         = 8'h73;
  localparam logic [7:0]  CHAR_D         = 8'h64;
  localparam logic [7:0]  CHAR_Q         = 8'h71;
  localparam logic [15:0] DEBOUNCE_RESET = 16'd250;

  typedef enum logic [2:0] {
    CMD_NONE = 3'd0,
    CMD_M    = 3'd1,
    CMD_N    = 3'd2,
    CMD_Z    = 3'd3,
    CMD_X    = 3'd4,
    CMD_I    = 3'd5
  } cmd_e;

  typedef enum logic [2:0] {
    DIR_NONE  = 3'd0,
    DIR_FWD   = 3'd1,
    DIR_LEFT  = 3'd2,
    DIR_BACK  = 3'd3,
    DIR_RIGHT = 3'd4
  } dir_e;

  // input tdata, highest bits first
  typedef struct packed {
    logic [6:0]  pad;
    logic        scan_busy;
    logic [31:0] now_ms;
    logic [7:0]  rx_byte;
  } item_t;

  // output tdata, highest bits first
  typedef struct packed {
    logic [3:0]  pad;
    logic        dropped;
    cmd_e        status_code;
    logic [31:0] move_stamp;
    dir_e        move_dir;
    logic        scan_request;
    logic        stopped;
    logic        started;
    logic        auto_on;
    logic        manual_on;
    logic [7:0]  tx_byte;
  } out_data_t;

  typedef struct packed {
    out_data_t data;
    logic      last;
  } result_t;

  typedef struct packed {
    logic valid;
    logic phase;
  } in_ctrl_t;

  function automatic logic [7:0] fold_lower(input logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) r = b + CASE_OFFSET;
    return r;
  endfunction

  function automatic cmd_e command_code(input logic [7:0] c);
    cmd_e r;
    case (c)
      CHAR_M:  r = CMD_M;
      CHAR_N:  r = CMD_N;
      CHAR_Z:  r = CMD_Z;
      CHAR_X:  r = CMD_X;
      CHAR_I:  r = CMD_I;
      default: r = CMD_NONE;
    endcase
    return r;
  endfunction

endpackage

// File: hw/rtl/scmd_in_reg.sv
// ----------------------------------------------------------------------------
// scmd_in_reg
// Input request register; holds a carriage return for a second pass so that
// the newline follows it.
// ----------------------------------------------------------------------------
module scmd_in_reg
  import scmd_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  input  item_t    in_item_i,
  output logic     in_ready_o,
  input  logic     adv_i,
  output item_t    item_o,
  output in_ctrl_t ctrl_o
);

  logic  valid_q, valid_d;
  logic  phase_q, phase_d;
  item_t item_q;
  logic  is_cr;
  logic  done;
  logic  take;

  assign is_cr      = (item_q.rx_byte == CHAR_CR);
  assign done       = adv_i && (!is_cr || phase_q);
  assign in_ready_o = !valid_q || done;
  assign take       = in_valid_i && in_ready_o;

  always_comb begin
    valid_d = valid_q;
    phase_d = phase_q;
    if (take) begin
      valid_d = 1'b1;
      phase_d = 1'b0;
    end else if (done) begin
      valid_d = 1'b0;
      phase_d = 1'b0;
    end else if (adv_i) begin
      phase_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      phase_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
      phase_q <= phase_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      item_q <= in_item_i;
    end
  end

  assign item_o       = item_q;
  assign ctrl_o.valid = valid_q;
  assign ctrl_o.phase = phase_q;

endmodule

// File: hw/rtl/scmd_decode.sv
// ----------------------------------------------------------------------------
// scmd_decode
// Mode state, debounce window register and command decode for one request.
// ----------------------------------------------------------------------------
module scmd_decode
  import scmd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  input  logic        adv_i,
  input  item_t       item_i,
  input  in_ctrl_t    ctrl_i,
  output result_t     result_o
);

  logic [15:0] window_q;
  logic        manual_q, manual_d;
  logic        auto_q, auto_d;
  logic        start_q, start_d;
  logic        stop_q, stop_d;
  logic        scan_q, scan_d;
  dir_e        dir_q, dir_d;
  logic [31:0] dir_time_q, dir_time_d;
  cmd_e        status_q, status_d;
  cmd_e        prev_q, prev_d;
  logic [31:0] prev_time_q, prev_time_d;

  logic        is_cr;
  logic [7:0]  c;
  cmd_e        code;
  logic [31:0] elapsed;
  logic        drop;

  assign is_cr   = (item_i.rx_byte == CHAR_CR);
  assign c       = fold_lower(item_i.rx_byte);
  assign code    = command_code(c);
  assign elapsed = item_i.now_ms - prev_time_q;

  always_comb begin
    manual_d    = manual_q;
    auto_d      = auto_q;
    start_d     = start_q;
    stop_d      = stop_q;
    scan_d      = scan_q;
    dir_d       = dir_q;
    dir_time_d  = dir_time_q;
    status_d    = status_q;
    prev_d      = prev_q;
    prev_time_d = prev_time_q;
    drop        = 1'b0;
    if (!is_cr) begin
      if (code != CMD_NONE && code == prev_q && elapsed < {16'd0, window_q}) begin
        drop = 1'b1;
      end else begin
        if (code != CMD_NONE) begin
          prev_d      = code;
          prev_time_d = item_i.now_ms;
        end
        case (code)
          CMD_M: begin
            if (!manual_q) begin
              manual_d = 1'b1; auto_d = 1'b0; start_d = 1'b0; stop_d = 1'b0;
              scan_d = 1'b0; dir_d = DIR_NONE; status_d = CMD_M;
            end
          end
          CMD_N: begin
            if (!auto_q) begin
              auto_d = 1'b1; manual_d = 1'b0; start_d = 1'b0; stop_d = 1'b0;
              scan_d = 1'b0; dir_d = DIR_NONE; status_d = CMD_N;
            end
          end
          CMD_Z: begin
            if (auto_q && !start_q) begin
              start_d = 1'b1; stop_d = 1'b0; status_d = CMD_Z;
            end
          end
          CMD_X: begin
            if (manual_q || auto_q || start_q || scan_q || item_i.scan_busy ||
                dir_q != DIR_NONE) begin
              stop_d = 1'b1; start_d = 1'b0; scan_d = 1'b0;
              dir_d = DIR_NONE; status_d = CMD_X;
            end
          end
          CMD_I: begin
            if (manual_q && !item_i.scan_busy && !scan_q) begin
              scan_d = 1'b1; dir_d = DIR_NONE; status_d = CMD_I;
            end
          end
          default: begin
            if (manual_q) begin
              case (c)
                CHAR_W: begin dir_d = DIR_FWD;   dir_time_d = item_i.now_ms; end
                CHAR_A: begin dir_d = DIR_LEFT;  dir_time_d = item_i.now_ms; end
                CHAR_S: begin dir_d = DIR_BACK;  dir_time_d = item_i.now_ms; end
                CHAR_D: begin dir_d = DIR_RIGHT; dir_time_d = item_i.now_ms; end
                CHAR_Q: dir_d = DIR_NONE;
                default: ;
              endcase
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q    <= DEBOUNCE_RESET;
      manual_q    <= 1'b0;
      auto_q      <= 1'b0;
      start_q     <= 1'b0;
      stop_q      <= 1'b0;
      scan_q      <= 1'b0;
      dir_q       <= DIR_NONE;
      dir_time_q  <= '0;
      status_q    <= CMD_NONE;
      prev_q      <= CMD_NONE;
      prev_time_q <= '0;
    end else begin
      if (cfg_we_i) begin
        window_q <= cfg_wdata_i;
      end
      if (adv_i) begin
        manual_q    <= manual_d;
        auto_q      <= auto_d;
        start_q     <= start_d;
        stop_q      <= stop_d;
        scan_q      <= scan_d;
        dir_q       <= dir_d;
        dir_time_q  <= dir_time_d;
        status_q    <= status_d;
        prev_q      <= prev_d;
        prev_time_q <= prev_time_d;
      end
    end
  end

  always_comb begin
    result_o.data.pad          = '0;
    result_o.data.tx_byte      = (is_cr && ctrl_i.phase) ? CHAR_LF : item_i.rx_byte;
    result_o.data.manual_on    = manual_d;
    result_o.data.auto_on      = auto_d;
    result_o.data.started      = start_d;
    result_o.data.stopped      = stop_d;
    result_o.data.scan_request = scan_d;
    result_o.data.move_dir     = dir_d;
    result_o.data.move_stamp   = dir_time_d;
    result_o.data.status_code  = status_d;
    result_o.data.dropped      = drop;
    result_o.last              = !is_cr || ctrl_i.phase;
  end

endmodule

// File: hw/rtl/serial_command_mode_decoder.sv
// ----------------------------------------------------------------------------
// serial_command_mode_decoder
// Echoes serial bytes, adds a newline after a carriage return and tracks
// debounced mode commands and manual direction keys.
// ----------------------------------------------------------------------------
//  port group   dir  payload
//  s_axis       in   tdata[47:0]: rx_byte, now_ms, scan_busy
//  m_axis       out  tdata[55:0]: echo byte and state flags; tlast: last_of_run
//  cfg          in   cfg_we_i / cfg_wdata_i[15:0]: debounce_window_ms
//
//  One result leaves the output register per cycle while m_axis is ready.
//  A byte yields one result, a carriage return two, both via that register.
//  A new request is taken while a result waits, as long as the output
//  register can advance. Reset clears all flags, the window goes to 250 ms.
// ----------------------------------------------------------------------------
module serial_command_mode_decoder
  import scmd_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // rx_byte[7:0], now_ms[39:8], scan_busy[40], zero[47:41]
  input  logic [47:0] s_axis_tdata_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // tx_byte[7:0], manual_on[8], auto_on[9], started[10], stopped[11],
  // scan_request[12], move_dir[15:13], move_stamp[47:16], status_code[50:48],
  // dropped[51], zero[55:52]
  output logic [55:0] m_axis_tdata_o,
  output logic        m_axis_tlast_o,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i
);

  item_t     item;
  in_ctrl_t  ctrl;
  result_t   result;
  logic      adv;
  logic      out_valid_q, out_valid_d;
  out_data_t out_data_q;
  logic      out_last_q;

  assign adv = ctrl.valid && (!out_valid_q || m_axis_tready_i);

  scmd_in_reg u_in_reg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_item_i  (item_t'(s_axis_tdata_i)),
    .in_ready_o (s_axis_tready_o),
    .adv_i      (adv),
    .item_o     (item),
    .ctrl_o     (ctrl)
  );

  scmd_decode u_decode (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .adv_i       (adv),
    .item_i      (item),
    .ctrl_i      (ctrl),
    .result_o    (result)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (adv) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_data_q <= result.data;
      out_last_q <= result.last;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tlast_o  = out_last_q;

  a_cr_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && out_data_q.tx_byte == CHAR_CR |-> !m_axis_tlast_o)
    else $error("carriage return echoed as last result");

  a_drop_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && out_data_q.dropped |-> m_axis_tlast_o)
    else $error("dropped request produced more than one result");

  a_modes_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(out_data_q.manual_on && out_data_q.auto_on))
    else $error("manual and auto mode both set");

  a_newline_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.phase |-> ctrl.valid && item.rx_byte == CHAR_CR)
    else $error("second pass without a held carriage return");

  a_split_then_newline: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv && !result.last |=> ctrl.phase && !s_axis_tready_o || ctrl.phase && adv)
    else $error("newline pass lost after carriage return");

endmodule
